[hw/rtl/ahash_pkg.sv]
`timescale 1ns / 1ps
package ahash_pkg;

	localparam int MAX_PIXELS_DEF = 64;

	localparam int WORD_W  = 32;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_ENABLE = 1'd1;

	localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 7'd64;
	localparam logic               GRAY_ENABLE_RST = 1'b1;

	// Luma weights in percent.
	localparam int WSUM_W = 15;
	localparam logic [WSUM_W-1:0] GRAY_R_WT = 15'd30;
	localparam logic [WSUM_W-1:0] GRAY_G_WT = 15'd59;
	localparam logic [WSUM_W-1:0] GRAY_B_WT = 15'd11;

	// floor(x / 100) == (x * 5243) >> 19 for every x below 25600.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	typedef struct packed {
		logic load;
		logic div_start;
		logic rd_en;
		logic out_load;
		logic out_last;
	} ahash_cmd_t;

endpackage

[hw/rtl/ahash_ram.sv]
`timescale 1ns / 1ps
module ahash_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/ahash_div.sv]
`timescale 1ns / 1ps
module ahash_div #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int ITER_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic              fits;
	logic [DEN_W:0]    diff;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of quo_q while quotient bits shift in at the bottom.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(NUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[hw/rtl/ahash_dp.sv]
`timescale 1ns / 1ps
module ahash_dp import ahash_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ahash_cmd_t         cmd,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0]  pixel_word,
	input  logic               gray_en,
	input  logic [CNT_W-1:0]   div_n,
	input  logic [ADDR_W-1:0]  rd_addr,
	input  logic [INDEX_W-1:0] out_index,
	output logic               div_done,
	output logic               mask_bit,
	output logic [INDEX_W-1:0] pixel_index,
	output logic [WORD_W-1:0]  mean_word,
	output logic               last_bit
);

	localparam int SUM_W  = WORD_W + $clog2(MAX_PIXELS);
	localparam int PROD_W = WSUM_W + RECIP_W;

	logic [WORD_W-1:0] px_s1;
	logic [WSUM_W-1:0] wsum_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              gray_s1;
	logic              vld_s1;

	logic [WSUM_W-1:0] wsum;
	logic [PROD_W-1:0] prod;
	logic [7:0]        luma;
	logic [WORD_W-1:0] word_s2;

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  quo;
	logic [WORD_W-1:0] rd_word;

	logic               mask_q;
	logic [INDEX_W-1:0] index_q;
	logic [WORD_W-1:0]  mean_q;
	logic               last_q;

	// Weighted sum is formed on the way in; the divide by 100 happens a stage later.
	always_comb begin
		wsum = WSUM_W'(pixel_word[23:16]) * GRAY_R_WT
			+ WSUM_W'(pixel_word[15:8]) * GRAY_G_WT
			+ WSUM_W'(pixel_word[7:0]) * GRAY_B_WT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_s1   <= pixel_word;
			wsum_s1 <= wsum;
			addr_s1 <= wr_addr;
			gray_s1 <= gray_en;
		end
	end

	always_comb begin
		prod    = PROD_W'(wsum_s1) * PROD_W'(RECIP_100);
		luma    = prod[RECIP_SHIFT+7:RECIP_SHIFT];
		word_s2 = gray_s1 ? {px_s1[31:24], luma, luma, luma} : px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.div_start) begin
			sum_q <= '0;
		end else if (vld_s1) begin
			sum_q <= sum_q + SUM_W'(word_s2);
		end
	end

	ahash_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (addr_s1),
		.wdata (word_s2),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	ahash_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (div_n),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mask_q  <= rd_word > quo[WORD_W-1:0];
			index_q <= out_index;
			mean_q  <= quo[WORD_W-1:0];
			last_q  <= cmd.out_last;
		end
	end

	assign mask_bit    = mask_q;
	assign pixel_index = index_q;
	assign mean_word   = mean_q;
	assign last_bit    = last_q;

endmodule

[hw/rtl/ahash_ctrl.sv]
`timescale 1ns / 1ps
module ahash_ctrl import ahash_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] pixel_count,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               div_done,
	output ahash_cmd_t         cmd,
	output logic [ADDR_W-1:0]  wr_addr,
	output logic [CNT_W-1:0]   div_n,
	output logic [ADDR_W-1:0]  rd_addr,
	output logic [INDEX_W-1:0] out_index
);

	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_START,
		ST_DIV,
		ST_RD,
		ST_CMP,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] k_q;
	logic             out_valid_q;

	logic [CMP_W-1:0] pc_ext;
	logic [CNT_W-1:0] eff_cnt;
	logic [CNT_W-1:0] cnt_inc;
	logic             accept;
	logic             frame_end;
	logic             out_take;

	// A count of zero acts as one; a count above the store depth is clamped.
	always_comb begin
		pc_ext = CMP_W'(pixel_count);
		if (pc_ext == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (pc_ext > CMP_W'(MAX_PIXELS)) begin
			eff_cnt = CNT_W'(MAX_PIXELS);
		end else begin
			eff_cnt = CNT_W'(pc_ext);
		end
	end

	always_comb begin
		in_stall  = state_q != ST_LOAD;
		accept    = in_valid && !in_stall;
		cnt_inc   = cnt_q + CNT_W'(1);
		frame_end = cnt_inc >= eff_cnt;
		out_take  = out_valid_q && !out_stall;

		cmd.load      = accept;
		cmd.div_start = state_q == ST_START;
		cmd.rd_en     = state_q == ST_RD;
		cmd.out_load  = state_q == ST_CMP;
		cmd.out_last  = k_q == (n_q - CNT_W'(1));

		wr_addr   = cnt_q[ADDR_W-1:0];
		div_n     = n_q;
		rd_addr   = k_q[ADDR_W-1:0];
		out_index = INDEX_W'(k_q);
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (frame_end) begin
							n_q     <= cnt_inc;
							cnt_q   <= '0;
							state_q <= ST_FLUSH;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				// The last pixel lands in the store and the sum in this cycle.
				ST_FLUSH: begin
					state_q <= ST_START;
				end
				ST_START: begin
					k_q     <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_take) begin
						out_valid_q <= 1'b0;
						if (cmd.out_last) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

[hw/rtl/average_hash_mask.sv]
`timescale 1ns / 1ps
// Average-hash mask generator. Pixels (ARGB, one per beat) are taken one per
// cycle while a frame loads; with gray_enable set each is turned into alpha
// plus a replicated luma value before it is stored and summed. When the
// configured count is reached, input stalls while the mean is formed by a
// bit-serial divider, after a flush and a start step. The mask then leaves
// in load order, each beat passing through the store read, compare and
// output register steps, with the next beat read only once the last is
// taken, so an output stall holds it; the last beat carries last_bit. Input
// resumes on the cycle after the last beat is taken. Configuration writes
// are always ready and take effect from the next pixel; lowering the count
// below what is already loaded closes the frame on that pixel.
module average_hash_mask import ahash_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [WORD_W-1:0]     pixel_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  mask_bit,
	output logic [INDEX_W-1:0]    pixel_index,
	output logic [WORD_W-1:0]     mean_word,
	output logic                  last_bit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1);

	logic [COUNT_W-1:0] pixel_count_q;
	logic               gray_enable_q;

	ahash_cmd_t         cmd;
	logic               div_done;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CNT_W-1:0]   div_n;
	logic [INDEX_W-1:0] out_index;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIXEL_COUNT_RST;
			gray_enable_q <= GRAY_ENABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data[COUNT_W-1:0];
				REG_GRAY_ENABLE: gray_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ahash_ctrl #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_count (pixel_count_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.div_done    (div_done),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.div_n       (div_n),
		.rd_addr     (rd_addr),
		.out_index   (out_index)
	);

	ahash_dp #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.pixel_word  (pixel_word),
		.gray_en     (gray_enable_q),
		.div_n       (div_n),
		.rd_addr     (rd_addr),
		.out_index   (out_index),
		.div_done    (div_done),
		.mask_bit    (mask_bit),
		.pixel_index (pixel_index),
		.mean_word   (mean_word),
		.last_bit    (last_bit)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

typedef struct {
	logic                            mask;
	logic [ahash_pkg::INDEX_W-1:0]   idx;
	logic [ahash_pkg::WORD_W-1:0]    mean;
	logic                            last;
} mask_beat_t;

// Tracks frame loading and the mean/mask beats each completed frame will produce.
class mask_frame_tracker;
	logic [ahash_pkg::COUNT_W-1:0] count_reg;
	logic                          gray_reg;
	logic [ahash_pkg::WORD_W-1:0]  frame_words [ahash_pkg::MAX_PIXELS_DEF];
	logic [37:0]                   frame_sum;
	int unsigned                   loaded;
	mask_beat_t                    due_beats [$];

	function new();
		count_reg = ahash_pkg::PIXEL_COUNT_RST;
		gray_reg  = ahash_pkg::GRAY_ENABLE_RST;
		frame_sum = '0;
		loaded    = 0;
	endfunction

	function void set_reg(logic [ahash_pkg::CFG_IDX_W-1:0] idx,
			logic [ahash_pkg::CFG_DATA_W-1:0] data);
		if (idx == ahash_pkg::REG_PIXEL_COUNT) begin
			count_reg = data[ahash_pkg::COUNT_W-1:0];
		end else if (idx == ahash_pkg::REG_GRAY_ENABLE) begin
			gray_reg = data[0];
		end
	endfunction

	function void note_pixel(logic [ahash_pkg::WORD_W-1:0] word);
		int unsigned r, g, b, y, n;
		logic [37:0] quot;
		logic [ahash_pkg::WORD_W-1:0] w;
		logic [ahash_pkg::WORD_W-1:0] mean;
		mask_beat_t beat;
		w = word;
		if (gray_reg) begin
			r = w[23:16];
			g = w[15:8];
			b = w[7:0];
			y = (r * 30 + g * 59 + b * 11) / 100;
			w = {w[31:24], y[7:0], y[7:0], y[7:0]};
		end
		if (loaded < ahash_pkg::MAX_PIXELS_DEF) begin
			frame_words[loaded] = w;
			frame_sum = frame_sum + {6'd0, w};
			loaded++;
		end
		n = count_reg;
		if (n == 0)
			n = 1;
		if (n > ahash_pkg::MAX_PIXELS_DEF)
			n = ahash_pkg::MAX_PIXELS_DEF;
		if (loaded < n)
			return;
		quot = frame_sum / loaded;
		mean = quot[ahash_pkg::WORD_W-1:0];
		for (int k = 0; k < loaded; k++) begin
			beat.mask = (frame_words[k] > mean);
			beat.idx  = k[ahash_pkg::INDEX_W-1:0];
			beat.mean = mean;
			beat.last = (k + 1 == loaded);
			due_beats.push_back(beat);
		end
		frame_sum = '0;
		loaded    = 0;
	endfunction

	function int beats_due();
		return due_beats.size();
	endfunction

	// Returns an empty string when the beat matches the oldest one due.
	function string check_beat(mask_beat_t got);
		mask_beat_t want;
		if (due_beats.size() == 0)
			return $sformatf("beat with index %0d arrived with none due", got.idx);
		want = due_beats.pop_front();
		if (got.mask !== want.mask || got.idx !== want.idx ||
				got.mean !== want.mean || got.last !== want.last)
			return $sformatf("got mask %b idx %0d mean %h last %b, want mask %b idx %0d mean %h last %b",
				got.mask, got.idx, got.mean, got.last,
				want.mask, want.idx, want.mean, want.last);
		return "";
	endfunction
endclass

module tb;
	import ahash_pkg::*;

	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [WORD_W-1:0]     pixel_word;
	logic                  out_valid;
	logic                  out_stall;
	logic                  mask_bit;
	logic [INDEX_W-1:0]    pixel_index;
	logic [WORD_W-1:0]     mean_word;
	logic                  last_bit;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mask_frame_tracker tracker = new();
	logic [WORD_W-1:0] burst [$];
	int idle_pct   = 0;
	int stall_pct  = 0;
	int hold_order = 0;
	int hold_left  = 0;
	int mismatches = 0;

	average_hash_mask dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_word  (pixel_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mask_bit    (mask_bit),
		.pixel_index (pixel_index),
		.mean_word   (mean_word),
		.last_bit    (last_bit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Drives every queued pixel; each beat may be preceded by a random gap.
	task automatic send_burst();
		logic [WORD_W-1:0] w;
		int gap;
		while (burst.size() != 0) begin
			w = burst.pop_front();
			gap = 0;
			while ($urandom_range(99) < idle_pct && gap < 40)
				gap++;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid   <= 1'b1;
			pixel_word <= w;
			do @(posedge clk); while (in_stall);
			tracker.note_pixel(w);
			@(negedge clk);
		end
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (tracker.beats_due() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic fill_frame(input int n);
		int style;
		logic [WORD_W-1:0] base;
		style = $urandom_range(2);
		base  = $urandom;
		for (int i = 0; i < n; i++) begin
			case (style)
				0: burst.push_back($urandom);
				1: burst.push_back({base[31:24], 24'($urandom)});
				default: burst.push_back(base ^ 32'($urandom_range(7)));
			endcase
		end
	endtask

	// Output side: random stalls, plus a long hold-off when one is ordered.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_order > 0) begin
				hold_left  = hold_order;
				hold_order = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin : beat_check
		mask_beat_t got;
		string msg;
		if (arst_n && out_valid && !out_stall) begin
			got.mask = mask_bit;
			got.idx  = pixel_index;
			got.mean = mean_word;
			got.last = last_bit;
			msg = tracker.check_beat(got);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin : stimulus
		int cnt, n, pick, phase_items;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		pixel_word = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_PIXEL_COUNT;
		cfg_data   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Partial frame at reset settings, then the count is lowered below what is
		// already loaded: the next pixel closes a three-pixel frame.
		burst = '{32'h1234_5678, 32'hFF00_0000};
		send_burst();
		wait_drained();
		write_reg(REG_PIXEL_COUNT, 7'd2);
		burst = '{32'hFFFF_FFFF};
		send_burst();
		wait_drained();

		write_reg(REG_PIXEL_COUNT, 7'd1);
		burst = '{32'h0000_0000, 32'hFFFF_FFFF};
		send_burst();
		wait_drained();

		// Gray off with the upper data bits set; a count of zero behaves as one.
		write_reg(REG_GRAY_ENABLE, 7'b111_1110);
		write_reg(REG_PIXEL_COUNT, 7'd0);
		burst = '{32'hA5A5_A5A5, 32'h5A5A_5A5A};
		send_burst();
		wait_drained();

		write_reg(REG_PIXEL_COUNT, 7'd4);
		burst = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
		send_burst();
		wait_drained();

		write_reg(REG_GRAY_ENABLE, 7'd1);
		write_reg(REG_PIXEL_COUNT, 7'd6);
		burst = '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF,
			32'hFF00_0000, 32'hFFFF_FFFF, 32'h0000_0000};
		send_burst();
		wait_drained();

		// Every word equals the mean, so no mask bit is set.
		write_reg(REG_PIXEL_COUNT, 7'd3);
		burst = '{32'h4040_4040, 32'h4040_4040, 32'h4040_4040};
		send_burst();
		wait_drained();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				3: begin idle_pct = 31; stall_pct = 31; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				wait_drained();
				pick = $urandom_range(19);
				if (phase == 0 && phase_items == 0)
					cnt = 127;
				else if (phase == 4 && phase_items == 0)
					cnt = 8;
				else if (pick < 12)
					cnt = $urandom_range(1, 8);
				else if (pick < 17)
					cnt = $urandom_range(9, 20);
				else if (pick == 17)
					cnt = 0;
				else if (pick == 18)
					cnt = $urandom_range(21, 40);
				else
					cnt = 1;
				n = (cnt == 0) ? 1 : ((cnt > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : cnt);
				write_reg(REG_PIXEL_COUNT, cnt[CFG_DATA_W-1:0]);
				write_reg(REG_GRAY_ENABLE, CFG_DATA_W'($urandom));
				if (phase == 4 && phase_items == 0) begin
					// Four frames back to back against a held-off output.
					for (int f = 0; f < 4; f++)
						fill_frame(n);
					phase_items += 4 * n;
					hold_order = HOLD_CYCLES;
				end else begin
					fill_frame(n);
					phase_items += n;
				end
				send_burst();
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
		wait_drained();

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
